// ----- src/sha1_stream_hasher_macros.svh -----
// Assertion macros shared by the checker files of the streaming SHA-1 hasher.
// Depends on nothing; included by the checker module.
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA1S_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHA1S_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sha1s_pkg.sv -----
// Shared types and constants of the streaming SHA-1 hasher.
// Depends on nothing; imported by every module of the block.
package sha1s_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_END      = 2'd1,
    CMD_BYTE_END = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  localparam logic [4:0][31:0] CHAIN_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [2:0] LAST_WORD_NUM = 3'd4;

endpackage

// ----- src/sha1s_fifo.sv -----
// Small command queue between the front and the back of the SHA-1 hasher.
// Depends on sha1s_pkg for the command type.
module sha1s_fifo
  import sha1s_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t           mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/sha1s_front.sv -----
// Input side of the SHA-1 hasher: takes items and turns them into commands.
// Depends on sha1s_pkg; feeds the command queue.
module sha1s_front
  import sha1s_pkg::*;
(
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  output logic     q_push,
  output cmd_t     q_cmd,
  input  logic     q_full
);

  // Items that carry neither a byte nor an end mark are taken and dropped.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (in_data.has_byte || in_data.end_of_message);

  always_comb begin
    q_cmd.data = in_data.data_byte;
    if (in_data.has_byte && in_data.end_of_message) begin
      q_cmd.kind = CMD_BYTE_END;
    end else if (in_data.has_byte) begin
      q_cmd.kind = CMD_BYTE;
    end else begin
      q_cmd.kind = CMD_END;
    end
  end

endmodule

// ----- src/sha1s_core.sv -----
// Back end of the SHA-1 hasher: block shift buffer, padding sequencer,
// one-round-per-cycle compression and digest output register. Uses sha1s_pkg.
module sha1s_core
  import sha1s_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD80, ST_PADZ, ST_PADLEN, ST_COMP, ST_ADD, ST_EMIT
  } state_t;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN  = 6'd55;
  localparam logic [6:0] RND_LAST  = 7'd79;

  state_t           state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [63:0]      bits_r, bits_nxt, len_r, len_nxt;
  logic [511:0]     blk_r, blk_nxt;
  logic [4:0][31:0] chain_r, chain_nxt;
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;
  logic [31:0]      a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [6:0]       rnd_r, rnd_nxt;
  logic [2:0]       wd_r, wd_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic        shift_en, start_comp, has_b, is_end, out_load;
  logic [7:0]  shift_byte;
  logic [31:0] w_cur, w_mix, w_new, f_val, k_val, t_val;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;

  // The buffer window holds w[t..t+15] with w[t] in the top word.
  assign w_cur = blk_r[511:480];
  assign w_mix = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ w_cur;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_R0;
    end else if (rnd_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_R1;
    end else if (rnd_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_R2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_R3;
    end
    t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + w_cur + k_val;
  end

  always_comb begin
    unique case (cmd.kind)
      CMD_BYTE:     begin has_b = 1'b1; is_end = 1'b0; end
      CMD_END:      begin has_b = 1'b0; is_end = 1'b1; end
      CMD_BYTE_END: begin has_b = 1'b1; is_end = 1'b1; end
      default:      begin has_b = 1'b0; is_end = 1'b0; end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    fill_nxt   = fill_r;
    bits_nxt   = bits_r;
    len_nxt    = len_r;
    blk_nxt    = blk_r;
    chain_nxt  = chain_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    e_nxt      = e_r;
    rnd_nxt    = rnd_r;
    wd_nxt     = wd_r;
    shift_en   = 1'b0;
    shift_byte = 8'h00;
    start_comp = 1'b0;
    out_load   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (has_b) begin
            shift_en   = 1'b1;
            shift_byte = cmd.data;
            bits_nxt   = bits_r + 64'd8;
          end
          if (has_b && fill_r == FILL_LAST) begin
            start_comp = 1'b1;
            ret_nxt    = is_end ? ST_PAD80 : ST_IDLE;
          end else if (is_end) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        shift_en   = 1'b1;
        shift_byte = PAD_BYTE;
        len_nxt    = bits_r;
        if (fill_r == FILL_LAST) begin
          start_comp = 1'b1;
          ret_nxt    = ST_PADZ;
        end else if (fill_r == FILL_LEN) begin
          state_nxt = ST_PADLEN;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        shift_en = 1'b1;
        if (fill_r == FILL_LAST) begin
          start_comp = 1'b1;
          ret_nxt    = ST_PADZ;
        end else if (fill_r == FILL_LEN) begin
          state_nxt = ST_PADLEN;
        end
      end
      ST_PADLEN: begin
        shift_en   = 1'b1;
        shift_byte = len_r[63:56];
        len_nxt    = {len_r[55:0], 8'h00};
        if (fill_r == FILL_LAST) begin
          start_comp = 1'b1;
          ret_nxt    = ST_EMIT;
        end
      end
      ST_COMP: begin
        blk_nxt = {blk_r[479:0], w_new};
        e_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        b_nxt   = a_r;
        a_nxt   = t_val;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        state_nxt    = ret_r;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          wd_nxt   = wd_r + 1'b1;
          if (wd_r == LAST_WORD_NUM) begin
            wd_nxt    = '0;
            chain_nxt = CHAIN_IV;
            bits_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (shift_en) begin
      blk_nxt  = {blk_r[503:0], shift_byte};
      fill_nxt = fill_r + 1'b1;
    end
    if (start_comp) begin
      state_nxt = ST_COMP;
      rnd_nxt   = '0;
      a_nxt     = chain_r[0];
      b_nxt     = chain_r[1];
      c_nxt     = chain_r[2];
      d_nxt     = chain_r[3];
      e_nxt     = chain_r[4];
    end

    out_data_nxt.digest_word = chain_r[wd_r];
    out_data_nxt.word_number = wd_r;
    out_data_nxt.last_word   = (wd_r == LAST_WORD_NUM);
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      chain_r     <= CHAIN_IV;
      rnd_r       <= '0;
      wd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      chain_r     <= chain_nxt;
      rnd_r       <= rnd_nxt;
      wd_r        <= wd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    len_r <= len_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

endmodule

// ----- src/sha1_stream_hasher.sv -----
// Top level of the streaming SHA-1 hasher: front, command queue and back end.
// Depends on sha1s_pkg, sha1s_front, sha1s_fifo and sha1s_core.
//
//   Channel  Direction  Payload     Handshake
//   in_      input      in_item_t   in_valid / in_stall
//   out_     output     out_item_t  out_valid / out_stall
//
// The 64th byte of a block starts a compression: 80 rounds, one per cycle in a
// single round unit, then a fold of the result into the chain words. An end of
// message shifts padding and length one byte per cycle up to the block end,
// runs one or two compressions, then sends five digest words at one per cycle
// while the output does not stall.
// Reset is synchronous and active low and returns the chain words to the
// standard initial values. Stalls on the output freeze the back end only while
// it has a digest word to send; the queue keeps taking items until it fills.
module sha1_stream_hasher
  import sha1s_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  // The front sorts items into byte, end, or byte-and-end commands and drops
  // items that carry neither. The queue lets it keep taking items while the
  // back end is busy with a compression.
  logic q_push, q_full, q_pop, q_not_empty;
  cmd_t q_in_cmd, q_out_cmd;

  sha1s_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_cmd    (q_in_cmd),
    .q_full   (q_full)
  );

  sha1s_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_out_cmd),
    .not_empty (q_not_empty)
  );

  // The back end holds the block in a 512-bit shift buffer. During the rounds
  // the same buffer shifts by one word each cycle and serves as the message
  // schedule window, so no separate schedule memory is needed.
  sha1s_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (q_out_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ----- src/sha1s_checker.sv -----
// Port-level checks for the streaming SHA-1 hasher, bound to the top level.
// Depends on sha1s_pkg and sha1_stream_hasher_macros.svh.
`include "sha1_stream_hasher_macros.svh"

module sha1s_checker
  import sha1s_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input in_item_t  in_data,
  input logic      in_stall,
  input logic      out_valid,
  input out_item_t out_data,
  input logic      out_stall
);

  logic [2:0] exp_r;
  logic       out_fire, out_wait, burst_go, word_ok, last_ok, in_ok;

  assign out_fire = out_valid && !out_stall;
  assign out_wait = out_valid && out_stall;
  assign burst_go = out_fire && !out_data.last_word;
  assign word_ok  = (out_data.word_number == exp_r);
  assign last_ok  = (out_data.last_word == (out_data.word_number == LAST_WORD_NUM));
  assign in_ok    = !$isunknown(in_data) && !$isunknown(in_stall);

  // Tracks which digest word should come next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
    end else if (out_fire) begin
      exp_r <= out_data.last_word ? 3'd0 : exp_r + 1'b1;
    end
  end

  `SHA1S_ASSERT_NXT(a_hold, clk, rst_n, out_wait, out_valid && $stable(out_data), "word changed")
  `SHA1S_ASSERT_IMP(a_order, clk, rst_n, out_valid, word_ok, "digest word out of order")
  `SHA1S_ASSERT_IMP(a_last, clk, rst_n, out_valid, last_ok, "last word flag mismatch")
  `SHA1S_ASSERT_NXT(a_burst, clk, rst_n, burst_go, out_valid, "gap inside digest burst")
  `SHA1S_ASSERT_IMP(a_in_known, clk, rst_n, in_valid, in_ok, "unknown input or stall")

endmodule

bind sha1_stream_hasher sha1s_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_data   (in_data),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);
